### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: item layouts,
// operation and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // Field widths of the item layouts
    localparam int MODE_FW = 2;
    localparam int KEY_FW  = 16;
    localparam int PAY_FW  = 16;
    localparam int OCC_FW  = 5;
    localparam int REM_FW  = 5;
    localparam int STS_FW  = 2;

    // Operation codes
    typedef enum logic [MODE_FW-1:0] {
        MODE_INSERT = 2'd0,
        MODE_POP    = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [STS_FW-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    // Input item
    typedef struct packed {
        t_mode             mode;
        logic [KEY_FW-1:0] entry_key;
        logic [PAY_FW-1:0] entry_payload;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic              head_valid;
        logic [KEY_FW-1:0] head_key;
        logic [PAY_FW-1:0] head_payload;
        logic [OCC_FW-1:0] occupancy;
        logic [REM_FW-1:0] removed_count;
        t_status           status;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;      // capture the accepted item
        logic exec;       // run insert/pop/peek, or start a remove scan
        logic scan_step;  // examine one slot of a remove scan
        logic push;       // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_remove;  // captured item is a remove
        logic empty;      // no entries held
        logic scan_last;  // scan cursor sits on slot zero
    } t_dp_stat;

endpackage

`default_nettype wire

### design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the sorted priority queue: handshakes on both channels and
// steps the datapath through execute, remove scan and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    input  wire spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    // result register can take a new item this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // commands decoded from state
    always_comb begin
        o_cmd           = '0;
        o_cmd.latch     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec      = (r_state == S_EXEC) && out_free;
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.push      = ((r_state == S_EXEC) && out_free && !i_stat.is_remove) ||
                          ((r_state == S_RESP) && out_free);
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        if (!i_stat.is_remove) begin
                            r_state <= S_IDLE;
                        end else if (i_stat.empty) begin
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (i_stat.scan_last) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (o_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### design/spq_array.sv
// ----------------------------------------------------------------------------
// spq_array
// Datapath of the sorted priority queue: a row of key/payload slots kept in
// order, with per-slot compare for insert, shift-down for delete, a scan
// cursor for remove, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_array #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire spq_pkg::t_in_item  i_in_item,
    input  wire spq_pkg::t_dp_cmd   i_cmd,
    output spq_pkg::t_dp_stat       o_stat,
    output spq_pkg::t_out_item      o_out_item
);

    localparam int IW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int KFW = spq_pkg::KEY_FW;
    localparam int PFW = spq_pkg::PAY_FW;
    localparam int OFW = spq_pkg::OCC_FW;
    localparam int RFW = spq_pkg::REM_FW;

    // slot storage and control registers
    logic [KEY_WIDTH-1:0]     r_key [QUEUE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] r_pay [QUEUE_DEPTH];
    logic [CW-1:0]            r_count;
    logic                     r_desc;
    spq_pkg::t_mode           r_mode;
    logic [KEY_WIDTH-1:0]     r_in_key;
    logic [PAYLOAD_WIDTH-1:0] r_in_pay;
    logic [IW-1:0]            r_cursor;
    logic [CW-1:0]            r_removed;
    spq_pkg::t_out_item       r_out_item;

    logic [QUEUE_DEPTH-1:0]   take;
    logic [QUEUE_DEPTH-1:0]   match;
    logic                     full;
    logic                     empty;
    logic                     hit;
    logic                     do_ins;
    logic                     do_del;
    logic [IW-1:0]            del_from;
    spq_pkg::t_out_item       n_res;

    assign full  = (r_count == CW'(QUEUE_DEPTH));
    assign empty = (r_count == '0);
    assign hit   = match[r_cursor];

    assign do_ins   = i_cmd.exec && (r_mode == spq_pkg::MODE_INSERT) && !full;
    assign do_del   = (i_cmd.exec && (r_mode == spq_pkg::MODE_POP) && !empty) ||
                      (i_cmd.scan_step && hit);
    assign del_from = i_cmd.scan_step ? r_cursor : '0;

    // per-slot insert position and payload match
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            take[i]  = (r_count <= CW'(i)) ||
                       (r_desc ? (r_in_key > r_key[i]) : (r_in_key < r_key[i]));
            match[i] = (r_pay[i] == r_in_pay);
        end
        // the first taking slot wins; every slot behind it shifts as well,
        // even when the held order no longer matches the current direction
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            take[i] = take[i] | take[i-1];
        end
    end

    // slot row: insert opens a gap at the first taking slot, delete closes one
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == QUEUE_DEPTH - 1) ? g : g + 1;
        logic prev_take;

        assign prev_take = (g == 0) ? 1'b0 : take[PREV];

        always_ff @(posedge i_clk) begin
            if (do_ins) begin
                if (prev_take) begin
                    r_key[g] <= r_key[PREV];
                    r_pay[g] <= r_pay[PREV];
                end else if (take[g]) begin
                    r_key[g] <= r_in_key;
                    r_pay[g] <= r_in_pay;
                end
            end else if (do_del && (IW'(g) >= del_from)) begin
                r_key[g] <= r_key[NEXT];
                r_pay[g] <= r_pay[NEXT];
            end
        end
    end

    // occupancy and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_desc  <= 1'b0;
        end else begin
            if (do_ins) begin
                r_count <= r_count + CW'(1);
            end else if (do_del) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cfg_we) begin
                r_desc <= i_cfg_wdata;
            end
        end
    end

    // captured item, remove scan cursor and tally
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode   <= i_in_item.mode;
            r_in_key <= KEY_WIDTH'(i_in_item.entry_key);
            r_in_pay <= PAYLOAD_WIDTH'(i_in_item.entry_payload);
        end
        if (i_cmd.exec && (r_mode == spq_pkg::MODE_REMOVE)) begin
            r_removed <= '0;
            r_cursor  <= IW'(r_count - CW'(1));
        end else if (i_cmd.scan_step) begin
            r_cursor <= r_cursor - IW'(1);
            if (hit) begin
                r_removed <= r_removed + CW'(1);
            end
        end
    end

    // result from the state before the operation (remove: after the scan)
    always_comb begin
        n_res           = '0;
        n_res.status    = spq_pkg::STS_OK;
        n_res.occupancy = OFW'(r_count);
        unique case (r_mode)
            spq_pkg::MODE_INSERT: begin
                if (full) begin
                    n_res.status = spq_pkg::STS_FULL;
                end else begin
                    n_res.occupancy = OFW'(r_count + CW'(1));
                end
            end
            spq_pkg::MODE_POP, spq_pkg::MODE_PEEK: begin
                if (empty) begin
                    n_res.status = spq_pkg::STS_EMPTY;
                end else begin
                    n_res.head_valid   = 1'b1;
                    n_res.head_key     = KFW'(r_key[0]);
                    n_res.head_payload = PFW'(r_pay[0]);
                    if (r_mode == spq_pkg::MODE_POP) begin
                        n_res.occupancy = OFW'(r_count - CW'(1));
                    end
                end
            end
            spq_pkg::MODE_REMOVE: begin
                n_res.removed_count = RFW'(r_removed);
            end
            default: begin
                n_res.status = spq_pkg::STS_OK;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_item <= n_res;
        end
    end

    assign o_out_item       = r_out_item;
    assign o_stat.is_remove = (r_mode == spq_pkg::MODE_REMOVE);
    assign o_stat.empty     = empty;
    assign o_stat.scan_last = (r_cursor == '0);

endmodule

`default_nettype wire

### design/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue of key/payload entries held in key order, equal
// keys first-in first-out. Insert, pop head, peek head, remove by payload.
//
//   Port group   Direction  Handshake               Content
//   i_in_*       in         i_in_valid / o_in_stall  t_in_item
//   o_out_*      out        o_out_valid / i_out_stall t_out_item
//   i_cfg_*      in         i_cfg_we                 descending order bit
//
// Insert, pop and peek: accept, then one compare-and-shift step across
// all slots. Remove: accept, then the scan cursor walks the held slots
// from the tail, one slot per cycle.
// A result waits in the output register; the next item is accepted behind
// it, and execution holds until that register is free.
// Reset clears the occupancy, the descending bit and both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire spq_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output spq_pkg::t_out_item      o_out_item
);

    spq_pkg::t_dp_cmd  dp_cmd;
    spq_pkg::t_dp_stat dp_stat;

    // sequencer
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // slot row and result register
    spq_array #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_array (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

### design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_stall,
    input wire logic               i_out_valid,
    input wire logic               i_out_stall,
    input wire spq_pkg::t_out_item i_out_item
);

    // no result is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // one item at a time: an accepted item blocks the input next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall) |=> i_in_stall)
        else $error("input accepted twice in a row");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_item)))
        else $error("stalled result changed");

    // a head entry is only shown with ok status
    a_head_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_item.head_valid) |->
            (i_out_item.status == spq_pkg::STS_OK && i_out_item.removed_count == '0))
        else $error("head shown with error status or removal tally");

    // an empty report carries no entries
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_item.status == spq_pkg::STS_EMPTY) |->
            (i_out_item.occupancy == '0 && !i_out_item.head_valid))
        else $error("empty status with entries held");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

`default_nettype wire

### test/sorted_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb
// Self-checking bench for the sorted priority queue. A behavioral copy of the
// queue predicts every result as items are accepted. Directed tests cover the
// empty queue, equal-key ordering, remove by payload and a full queue. Random
// traffic follows in both orders, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;

    localparam int QDEPTH       = 16;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_wdata = 1'b0;
    logic                i_in_valid  = 1'b0;
    spq_pkg::t_in_item   i_in_item   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    spq_pkg::t_out_item  o_out_item;

    // Behavioral copy of the queue
    logic [spq_pkg::KEY_FW-1:0] held_key [QDEPTH];
    logic [spq_pkg::PAY_FW-1:0] held_pay [QDEPTH];
    int                         held_count = 0;
    bit                         order_desc = 1'b0;

    // Results still owed by the block, oldest first
    spq_pkg::t_out_item pending_results [$];

    int fail_count    = 0;
    int result_number = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    sorted_priority_queue_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // New key is served ahead of a held key
    function automatic bit served_first(logic [spq_pkg::KEY_FW-1:0] new_key,
                                        logic [spq_pkg::KEY_FW-1:0] old_key);
        return order_desc ? (new_key > old_key) : (new_key < old_key);
    endfunction

    // Apply one operation to the queue copy and return the result it gives
    function automatic spq_pkg::t_out_item queue_step(spq_pkg::t_in_item op);
        spq_pkg::t_out_item r;
        int                 pos;
        int                 kept;
        r = '0;
        r.status = spq_pkg::STS_OK;
        case (op.mode)
            spq_pkg::MODE_INSERT: begin
                if (held_count >= QDEPTH) begin
                    r.status = spq_pkg::STS_FULL;
                end else begin
                    // first slot whose key the new key beats; ties go behind
                    pos = held_count;
                    for (int i = held_count - 1; i >= 0; i--)
                        if (served_first(op.entry_key, held_key[i])) pos = i;
                    for (int i = held_count; i > pos; i--) begin
                        held_key[i] = held_key[i-1];
                        held_pay[i] = held_pay[i-1];
                    end
                    held_key[pos] = op.entry_key;
                    held_pay[pos] = op.entry_payload;
                    held_count++;
                end
            end
            spq_pkg::MODE_POP, spq_pkg::MODE_PEEK: begin
                if (held_count == 0) begin
                    r.status = spq_pkg::STS_EMPTY;
                end else begin
                    r.head_valid   = 1'b1;
                    r.head_key     = held_key[0];
                    r.head_payload = held_pay[0];
                    if (op.mode == spq_pkg::MODE_POP) begin
                        for (int i = 1; i < held_count; i++) begin
                            held_key[i-1] = held_key[i];
                            held_pay[i-1] = held_pay[i];
                        end
                        held_count--;
                    end
                end
            end
            default: begin
                // compact the survivors toward the head
                kept = 0;
                for (int i = 0; i < held_count; i++) begin
                    if (held_pay[i] != op.entry_payload) begin
                        held_key[kept] = held_key[i];
                        held_pay[kept] = held_pay[i];
                        kept++;
                    end
                end
                r.removed_count = spq_pkg::REM_FW'(held_count - kept);
                held_count = kept;
            end
        endcase
        r.occupancy = spq_pkg::OCC_FW'(held_count);
        return r;
    endfunction

    function automatic spq_pkg::t_in_item queue_op(spq_pkg::t_mode mode,
                                                   logic [spq_pkg::KEY_FW-1:0] key,
                                                   logic [spq_pkg::PAY_FW-1:0] payload);
        spq_pkg::t_in_item op;
        op.mode          = mode;
        op.entry_key     = key;
        op.entry_payload = payload;
        return op;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    // Send one item; valid stays high afterwards so back-to-back items need no toggle
    task automatic send_item(input spq_pkg::t_in_item op);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= op;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(queue_step(op));
    endtask

    // Drain outstanding results, then write the order bit
    task automatic set_descending(input bit desc);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= desc;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        order_desc = desc;
    endtask

    // Result checker and receiver stall
    always @(posedge i_clk) begin
        spq_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          result_number));
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.head_valid !== want.head_valid)
                    report_mismatch($sformatf("result %0d head_valid got %0h exp %0h",
                        result_number, o_out_item.head_valid, want.head_valid));
                if (o_out_item.head_key !== want.head_key)
                    report_mismatch($sformatf("result %0d head_key got %0h exp %0h",
                        result_number, o_out_item.head_key, want.head_key));
                if (o_out_item.head_payload !== want.head_payload)
                    report_mismatch($sformatf("result %0d head_payload got %0h exp %0h",
                        result_number, o_out_item.head_payload, want.head_payload));
                if (o_out_item.occupancy !== want.occupancy)
                    report_mismatch($sformatf("result %0d occupancy got %0d exp %0d",
                        result_number, o_out_item.occupancy, want.occupancy));
                if (o_out_item.removed_count !== want.removed_count)
                    report_mismatch($sformatf("result %0d removed_count got %0d exp %0d",
                        result_number, o_out_item.removed_count, want.removed_count));
                if (o_out_item.status !== want.status)
                    report_mismatch($sformatf("result %0d status got %0d exp %0d",
                        result_number, o_out_item.status, want.status));
            end
            result_number++;
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sorted_priority_queue_top verification failed");
            $finish;
        end
    end

    // Pop, peek and remove on an empty queue
    task automatic test_empty_queue();
        set_descending(1'b0);
        send_item(queue_op(spq_pkg::MODE_POP,    16'h0000, 16'h0000));
        send_item(queue_op(spq_pkg::MODE_PEEK,   16'hFFFF, 16'hFFFF));
        send_item(queue_op(spq_pkg::MODE_REMOVE, 16'h0000, 16'h0000));
    endtask

    // Key extremes, equal keys leave in arrival order, remove with and without a match
    task automatic test_ties_and_remove();
        send_item(queue_op(spq_pkg::MODE_INSERT, 16'h8000, 16'h1234));
        send_item(queue_op(spq_pkg::MODE_INSERT, 16'hFFFF, 16'h1234));
        send_item(queue_op(spq_pkg::MODE_INSERT, 16'h8000, 16'h5678));
        send_item(queue_op(spq_pkg::MODE_INSERT, 16'h0000, 16'h0000));
        send_item(queue_op(spq_pkg::MODE_POP,    16'h0000, 16'h0000));
        send_item(queue_op(spq_pkg::MODE_PEEK,   16'h0000, 16'h0000));
        send_item(queue_op(spq_pkg::MODE_REMOVE, 16'h0000, 16'h1234));
        send_item(queue_op(spq_pkg::MODE_REMOVE, 16'hFFFF, 16'hFFFF));
    endtask

    // Fill to capacity, then one insert too many is dropped
    task automatic test_full_queue();
        while (held_count < QDEPTH)
            send_item(queue_op(spq_pkg::MODE_INSERT, 16'($urandom), 16'($urandom)));
        send_item(queue_op(spq_pkg::MODE_INSERT, 16'hFFFF, 16'hFFFF));
    endtask

    function automatic logic [spq_pkg::KEY_FW-1:0] random_key();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(7));      // many equal keys
            1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mixed operations; occupancy swings between empty and full in stretches
    task automatic test_random_traffic(input int count, input bit desc,
                                       input int idle_pct, input int busy_pct);
        spq_pkg::t_in_item op;
        int                fill_bias;
        int                pick;
        set_descending(desc);
        for (int n = 0; n < count; n++) begin
            // last fifth of each hundred runs without gaps or stalls
            send_idle_pct = ((n % 100) >= 80) ? 0 : idle_pct;
            stall_pct     = ((n % 100) >= 80) ? 0 : busy_pct;
            fill_bias = ((n / 40) % 2 == 0) ? 65 : 25;
            op.entry_key     = random_key();
            op.entry_payload = $urandom_range(1) ? 16'($urandom_range(7)) : 16'($urandom);
            if ($urandom_range(99) < fill_bias) begin
                op.mode = spq_pkg::MODE_INSERT;
            end else begin
                pick = $urandom_range(99);
                if (pick < 55)
                    op.mode = spq_pkg::MODE_POP;
                else if (pick < 75)
                    op.mode = spq_pkg::MODE_PEEK;
                else begin
                    op.mode = spq_pkg::MODE_REMOVE;
                    // mostly target a payload that is actually held
                    if (held_count > 0 && $urandom_range(9) < 7)
                        op.entry_payload = held_pay[$urandom_range(held_count - 1)];
                end
            end
            send_item(op);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_ties_and_remove();
        test_full_queue();
        test_random_traffic(420, 1'b1, 0, 0);
        test_random_traffic(420, 1'b0, 52, 0);
        test_random_traffic(420, 1'b1, 0, 52);
        test_random_traffic(420, 1'b0, 35, 35);

        // wait for every owed result, then let the pipeline settle
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("sorted_priority_queue_top verification clean");
        else
            $display("sorted_priority_queue_top verification failed");
        $finish;
    end

endmodule

### sim.f
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_array.sv
design/sorted_priority_queue_top.sv
design/spq_checker.sv
test/sorted_priority_queue_top_tb.sv
